// ===== rtl/assert_macros.svh =====
// Assertion macros for the decimal text converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define DTTI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define DTTI_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dtti_pkg.sv =====
// Package: constants, codes and types of the decimal text to integer unit
`timescale 1ns / 1ps

package dtti_pkg;

	// Widths
	localparam int VALUE_BITS_DEF = 64;
	localparam int OUT_BITS       = 64;
	localparam int CHAR_BITS      = 8;
	localparam int PHASE_BITS     = 3;
	localparam int STATUS_BITS    = 2;
	localparam int EXP_BITS       = 8;

	// Parse phases
	localparam logic [PHASE_BITS-1:0] PH_START    = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_MANT     = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_EXP_SIGN = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_EXP_NEED = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_EXP_DIG  = 3'd4;
	localparam logic [PHASE_BITS-1:0] PH_DONE     = 3'd5;

	// Result status codes
	localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_ILLEGAL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

	// Character codes
	localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_BITS-1:0] CH_LOW_E = 8'h65;
	localparam logic [CHAR_BITS-1:0] CH_UP_E  = 8'h45;

	// Decimal radix
	localparam logic [3:0] RADIX = 4'd10;
	localparam logic [EXP_BITS-1:0] EXP_MAX = 8'd255;

	// Shared unit operations
	localparam logic [1:0] ALU_MUL10 = 2'd0;
	localparam logic [1:0] ALU_SEED  = 2'd1;
	localparam logic [1:0] ALU_FOLD  = 2'd2;
	localparam logic [1:0] ALU_FIX   = 2'd3;

	// Request to the shared arithmetic unit
	typedef struct packed {
		logic [1:0] op;
		logic [3:0] digit;
		logic [1:0] sh;
	} alu_req_t;

	// Response of the shared arithmetic unit
	typedef struct packed {
		logic       ovf;
	} alu_rsp_t;

endpackage

// ===== rtl/dtti_if.sv =====
// Interfaces: character input channel and result output channel
`timescale 1ns / 1ps

interface dtti_in_if;
	logic                           valid;
	logic                           ready;
	logic [dtti_pkg::CHAR_BITS-1:0] char_in;
	logic                           last_char;

	modport source (output valid, char_in, last_char, input ready);
	modport sink (input valid, char_in, last_char, output ready);
endinterface

interface dtti_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [dtti_pkg::OUT_BITS-1:0]    value;
	logic        [dtti_pkg::STATUS_BITS-1:0] status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// ===== rtl/dtti_alu.sv =====
// Shared arithmetic unit: times ten plus digit, or one shift-add step of a divide by ten
`timescale 1ns / 1ps

module dtti_alu #(
	parameter int VALUE_BITS = dtti_pkg::VALUE_BITS_DEF
) (
	input  dtti_pkg::alu_req_t     req,
	input  logic [VALUE_BITS-1:0]  a,
	input  logic [VALUE_BITS-1:0]  b,
	output logic [VALUE_BITS-1:0]  y,
	output dtti_pkg::alu_rsp_t     rsp
);

	localparam int WW = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0] CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [WW-1:0] CAP_W = {4'b0, CAP};

	logic [WW-1:0]         wide;
	logic                  mul_ovf;
	logic [VALUE_BITS-1:0] seed;
	logic [VALUE_BITS-1:0] fold_sh;
	logic [VALUE_BITS-1:0] quo;
	logic [WW-1:0]         quo_next10;
	logic                  bump;

	// Multiply by ten and add the digit as shift-add, clamp to the magnitude cap
	assign wide    = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{(WW-4){1'b0}}, req.digit};
	assign mul_ovf = (wide > CAP_W);

	// Seed the quotient estimate with 0.75 of the dividend
	assign seed = (a >> 1) + (a >> 2);

	// Fold the estimate toward 0.8 of the dividend: shift by 4, 8, 16, then 32
	assign fold_sh = a >> (6'd4 << req.sh);

	// Scale the estimate by 1/8, then bump it when one more ten still fits in b
	assign quo        = a >> 3;
	assign quo_next10 = ({4'b0, quo} << 3) + ({4'b0, quo} << 1) +
		{{(WW-4){1'b0}}, dtti_pkg::RADIX};
	assign bump       = ({4'b0, b} >= quo_next10);

	always_comb begin
		rsp.ovf = 1'b0;
		case (req.op)
			dtti_pkg::ALU_SEED: begin
				y = seed;
			end
			dtti_pkg::ALU_FOLD: begin
				y = a + fold_sh;
			end
			dtti_pkg::ALU_FIX: begin
				y = quo + {{(VALUE_BITS-1){1'b0}}, bump};
			end
			default: begin
				rsp.ovf = mul_ovf;
				y       = mul_ovf ? CAP : wide[VALUE_BITS-1:0];
			end
		endcase
	end

endmodule

// ===== rtl/dtti_core.sv =====
// Parse state and sequencer: character parsing and exponent scaling loop
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtti_core #(
	parameter int VALUE_BITS = dtti_pkg::VALUE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [dtti_pkg::CHAR_BITS-1:0]        char_in,
	input  logic                                  last_char,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic signed [dtti_pkg::OUT_BITS-1:0]  res_value,
	output logic [dtti_pkg::STATUS_BITS-1:0]      res_status
);

	localparam logic [VALUE_BITS-1:0] CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_FIN  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	// Divide steps: seed, four folds, final fix
	localparam logic [2:0] DIV_LAST = 3'd5;

	logic [1:0]                          state_q;
	logic [dtti_pkg::PHASE_BITS-1:0]     phase_q;
	logic [VALUE_BITS-1:0]               mag_q;
	logic                                neg_q;
	logic [dtti_pkg::EXP_BITS-1:0]       exp_q;
	logic                                exp_neg_q;
	logic                                digit_q;
	logic                                ill_q;
	logic                                ovf_q;
	logic [VALUE_BITS-1:0]               div_q;
	logic [2:0]                          cnt_q;
	logic signed [dtti_pkg::OUT_BITS-1:0] value_q;
	logic [dtti_pkg::STATUS_BITS-1:0]    status_q;

	logic                                in_fire;
	logic                                is_digit;
	logic [3:0]                          dval;
	logic [11:0]                         exp_wide;

	dtti_pkg::alu_req_t                  alu_req;
	dtti_pkg::alu_rsp_t                  alu_rsp;
	logic [VALUE_BITS-1:0]               alu_a;
	logic [VALUE_BITS-1:0]               alu_y;

	// Next parse state for an accepted character
	logic [dtti_pkg::PHASE_BITS-1:0]     phase_n;
	logic [VALUE_BITS-1:0]               mag_n;
	logic                                neg_n;
	logic [dtti_pkg::EXP_BITS-1:0]       exp_n;
	logic                                exp_neg_n;
	logic                                digit_n;
	logic                                ill_n;
	logic                                ovf_n;

	// Finish values
	logic                                fin_ill;
	logic signed [VALUE_BITS-1:0]        sat_v;
	logic signed [VALUE_BITS-1:0]        mag_v;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign res_valid  = (state_q == S_OUT);
	assign res_value  = value_q;
	assign res_status = status_q;

	assign is_digit = (char_in >= dtti_pkg::CH_ZERO) && (char_in <= dtti_pkg::CH_NINE);
	assign dval     = char_in[3:0];
	assign exp_wide = ({4'b0, exp_q} << 3) + ({4'b0, exp_q} << 1) + {8'b0, dval};

	// Steer the shared unit by sequencer state
	always_comb begin
		alu_req = '0;
		alu_a   = mag_q;
		case (state_q)
			S_DIV: begin
				alu_a = div_q;
				if (cnt_q == '0) begin
					alu_req.op = dtti_pkg::ALU_SEED;
					alu_a      = mag_q;
				end else if (cnt_q == DIV_LAST) begin
					alu_req.op = dtti_pkg::ALU_FIX;
				end else begin
					alu_req.op = dtti_pkg::ALU_FOLD;
					alu_req.sh = 2'(cnt_q - 3'd1);
				end
			end
			S_FIN: begin
				alu_req.op = dtti_pkg::ALU_MUL10;
			end
			default: begin
				alu_req.op    = dtti_pkg::ALU_MUL10;
				alu_req.digit = dval;
			end
		endcase
	end

	dtti_alu #(
		.VALUE_BITS(VALUE_BITS)
	) u_alu (
		.req (alu_req),
		.a   (alu_a),
		.b   (mag_q),
		.y   (alu_y),
		.rsp (alu_rsp)
	);

	// Parse one character
	always_comb begin
		phase_n   = phase_q;
		mag_n     = mag_q;
		neg_n     = neg_q;
		exp_n     = exp_q;
		exp_neg_n = exp_neg_q;
		digit_n   = digit_q;
		ill_n     = ill_q;
		ovf_n     = ovf_q;
		if (!ill_q && (phase_q != dtti_pkg::PH_DONE)) begin
			if (char_in == dtti_pkg::CH_NUL) begin
				if ((phase_q == dtti_pkg::PH_EXP_SIGN) || (phase_q == dtti_pkg::PH_EXP_NEED)) begin
					ill_n = 1'b1;
				end
				phase_n = dtti_pkg::PH_DONE;
			end else begin
				case (phase_q)
					dtti_pkg::PH_START, dtti_pkg::PH_MANT: begin
						if ((phase_q == dtti_pkg::PH_START) && (char_in == dtti_pkg::CH_MINUS)) begin
							neg_n   = 1'b1;
							phase_n = dtti_pkg::PH_MANT;
						end else if (is_digit) begin
							mag_n   = alu_y;
							ovf_n   = ovf_q || alu_rsp.ovf;
							digit_n = 1'b1;
							phase_n = dtti_pkg::PH_MANT;
						end else if (((char_in == dtti_pkg::CH_LOW_E) ||
							(char_in == dtti_pkg::CH_UP_E)) && digit_q) begin
							phase_n = dtti_pkg::PH_EXP_SIGN;
						end else begin
							ill_n = 1'b1;
						end
					end
					dtti_pkg::PH_EXP_SIGN, dtti_pkg::PH_EXP_NEED, dtti_pkg::PH_EXP_DIG: begin
						if ((phase_q == dtti_pkg::PH_EXP_SIGN) &&
							((char_in == dtti_pkg::CH_PLUS) || (char_in == dtti_pkg::CH_MINUS))) begin
							exp_neg_n = (char_in == dtti_pkg::CH_MINUS);
							phase_n   = dtti_pkg::PH_EXP_NEED;
						end else if (is_digit) begin
							exp_n   = (exp_wide > {4'b0, dtti_pkg::EXP_MAX}) ?
								dtti_pkg::EXP_MAX : exp_wide[dtti_pkg::EXP_BITS-1:0];
							phase_n = dtti_pkg::PH_EXP_DIG;
						end else begin
							ill_n = 1'b1;
						end
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end
	end

	// Result patterns: saturated and in range
	assign fin_ill = ill_q || (phase_q == dtti_pkg::PH_EXP_SIGN) ||
		(phase_q == dtti_pkg::PH_EXP_NEED);
	assign sat_v   = neg_q ? CAP : (CAP - 1'b1);
	assign mag_v   = neg_q ? (~mag_q + 1'b1) : mag_q;

	// Sequence parsing, exponent scaling and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= dtti_pkg::PH_START;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			exp_q     <= '0;
			exp_neg_q <= 1'b0;
			digit_q   <= 1'b0;
			ill_q     <= 1'b0;
			ovf_q     <= 1'b0;
			div_q     <= '0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						phase_q   <= phase_n;
						mag_q     <= mag_n;
						neg_q     <= neg_n;
						exp_q     <= exp_n;
						exp_neg_q <= exp_neg_n;
						digit_q   <= digit_n;
						ill_q     <= ill_n;
						ovf_q     <= ovf_n;
						if (last_char) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (fin_ill || ovf_q || (exp_q == '0) || (mag_q == '0)) begin
						state_q <= S_OUT;
					end else if (exp_neg_q) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else if (alu_rsp.ovf) begin
						state_q <= S_OUT;
					end else begin
						mag_q <= alu_y;
						exp_q <= exp_q - 1'b1;
					end
				end
				S_DIV: begin
					// Advance the quotient estimate; the fix step yields the quotient
					if (cnt_q == DIV_LAST) begin
						mag_q   <= alu_y;
						exp_q   <= exp_q - 1'b1;
						state_q <= S_FIN;
					end else begin
						div_q <= alu_y;
						cnt_q <= cnt_q + 3'd1;
					end
				end
				default: begin
					// Drop the string state once the result is taken
					if (res_ready) begin
						state_q   <= S_IDLE;
						phase_q   <= dtti_pkg::PH_START;
						mag_q     <= '0;
						neg_q     <= 1'b0;
						exp_q     <= '0;
						exp_neg_q <= 1'b0;
						digit_q   <= 1'b0;
						ill_q     <= 1'b0;
						ovf_q     <= 1'b0;
					end
				end
			endcase
		end
	end

	// Capture the result when the loop ends
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			if (fin_ill) begin
				value_q  <= '0;
				status_q <= dtti_pkg::ST_ILLEGAL;
			end else if (ovf_q || ((exp_q != '0) && (mag_q != '0) && !exp_neg_q && alu_rsp.ovf) ||
				(!neg_q && (mag_q == CAP))) begin
				value_q  <= dtti_pkg::OUT_BITS'(sat_v);
				status_q <= dtti_pkg::ST_OVERFLOW;
			end else begin
				value_q  <= dtti_pkg::OUT_BITS'(mag_v);
				status_q <= dtti_pkg::ST_OK;
			end
		end
	end

	`DTTI_ASSERT_NEXT(a_last_busy, clk, arst_n, in_fire && last_char, state_q != S_IDLE, "last character did not start the finish sequence")
	`DTTI_ASSERT(a_div_step, clk, arst_n, (state_q == S_DIV) |-> (cnt_q <= DIV_LAST), "divide step counter out of range")
	`DTTI_ASSERT(a_mag_cap, clk, arst_n, (state_q != S_OUT) |-> (mag_q <= CAP), "magnitude above cap")
	`DTTI_ASSERT(a_ill_zero, clk, arst_n, (res_valid && (res_status == dtti_pkg::ST_ILLEGAL)) |-> (res_value == '0), "illegal result with nonzero value")

endmodule

// ===== rtl/decimal_text_to_integer_unit.sv =====
// Top level: decimal text to integer converter with registered result output
`timescale 1ns / 1ps
//
// Channel | Dir | Payload            | Beat
// text    | in  | char_in, last_char | one character of the number string
// result  | out | value, status      | one converted number per string
//
// A character that is not last is taken while the sequencer is idle. The last
// character starts the finish loop in the sequencer: each positive exponent
// step is a pass through the shared times-ten unit, and each negative exponent
// step is a decision step followed by the seed, fold and fix shift-add steps of
// the divide-by-ten; the loop stops when the exponent or the magnitude reaches
// zero, or when a step overflows. The result then goes to the output register.
// text.ready is low while the finish loop runs and while a finished result waits
// for the output register to drain. Reset needs no clearing pass.
//
module decimal_text_to_integer_unit #(
	parameter int VALUE_BITS = dtti_pkg::VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dtti_in_if.sink   text,
	dtti_out_if.source result
);

	logic                                 core_valid;
	logic                                 core_ready;
	logic signed [dtti_pkg::OUT_BITS-1:0] core_value;
	logic [dtti_pkg::STATUS_BITS-1:0]     core_status;
	logic                                 out_valid_q;
	logic signed [dtti_pkg::OUT_BITS-1:0] value_q;
	logic [dtti_pkg::STATUS_BITS-1:0]     status_q;

	dtti_core #(
		.VALUE_BITS(VALUE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (text.valid),
		.in_ready   (text.ready),
		.char_in    (text.char_in),
		.last_char  (text.last_char),
		.res_valid  (core_valid),
		.res_ready  (core_ready),
		.res_value  (core_value),
		.res_status (core_status)
	);

	// Output slot is free when empty or being drained this cycle
	assign core_ready = !out_valid_q || result.ready;

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ready) begin
			out_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			value_q  <= core_value;
			status_q <= core_status;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.value  = value_q;
	assign result.status = status_q;

endmodule

// ===== bench/tb_decimal_text_to_integer_unit.sv =====
// Testbench: decimal text to integer unit checked against a cycle-free predictor
`timescale 1ns / 1ps

module tb_decimal_text_to_integer_unit;
	import dtti_pkg::*;

	localparam int          VBITS      = VALUE_BITS_DEF;
	localparam logic [63:0] MAG_CAP    = 64'd1 << (VBITS - 1);
	localparam logic [63:0] TEN_U64    = 64'd10;
	localparam int          RAND_CHARS = 1050;
	localparam int          PHASE_LEN  = 360;
	localparam int          DRAIN      = 1500;

	typedef struct packed {
		logic [CHAR_BITS-1:0] ch;
		logic                 last;
	} text_beat_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] value;
		logic [STATUS_BITS-1:0]     status;
	} number_t;

	logic clk;
	logic arst_n = 1'b0;

	// Driven copies of the block inputs, known from time zero
	logic                 drv_valid = 1'b0;
	logic [CHAR_BITS-1:0] drv_char  = CH_NUL;
	logic                 drv_last  = 1'b0;
	logic                 rdy       = 1'b0;

	dtti_in_if  text_ch ();
	dtti_out_if result_ch ();

	assign text_ch.valid     = drv_valid;
	assign text_ch.char_in   = drv_char;
	assign text_ch.last_char = drv_last;
	assign result_ch.ready   = rdy;

	decimal_text_to_integer_unit #(.VALUE_BITS(VBITS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	text_beat_t           text_bytes[$];
	byte unsigned         text_buf[$];
	number_t              pending_numbers[$];
	int                   accepted_chars = 0;
	int                   mismatch_count = 0;

	// Predictor state of the parser
	logic [63:0]          mant_mag;
	logic                 mant_minus;
	logic [PHASE_BITS-1:0] parse_at;
	int unsigned          exp_count;
	logic                 exp_minus;
	logic                 saw_digit;
	logic                 saw_illegal;
	logic                 saw_overflow;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_number();
		mant_mag     = '0;
		mant_minus   = 1'b0;
		parse_at     = PH_START;
		exp_count    = 0;
		exp_minus    = 1'b0;
		saw_digit    = 1'b0;
		saw_illegal  = 1'b0;
		saw_overflow = 1'b0;
	endfunction

	// Advance the parser by one character
	function automatic void absorb_char(logic [CHAR_BITS-1:0] ch);
		logic                 is_dig;
		logic [CHAR_BITS-1:0] dch;
		logic [63:0]          d;
		int unsigned          e;
		is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
		dch    = ch - CH_ZERO;
		d      = {56'd0, dch};
		if (saw_illegal || parse_at == PH_DONE)
			return;
		if (ch == CH_NUL) begin
			if (parse_at == PH_EXP_SIGN || parse_at == PH_EXP_NEED)
				saw_illegal = 1'b1;
			parse_at = PH_DONE;
			return;
		end
		case (parse_at)
			PH_START, PH_MANT: begin
				if (parse_at == PH_START && ch == CH_MINUS) begin
					mant_minus = 1'b1;
					parse_at   = PH_MANT;
				end else if (is_dig) begin
					if (mant_mag > (MAG_CAP - d) / TEN_U64) begin
						mant_mag     = MAG_CAP;
						saw_overflow = 1'b1;
					end else begin
						mant_mag = mant_mag * TEN_U64 + d;
					end
					saw_digit = 1'b1;
					parse_at  = PH_MANT;
				end else if ((ch == CH_LOW_E || ch == CH_UP_E) && saw_digit) begin
					parse_at = PH_EXP_SIGN;
				end else begin
					saw_illegal = 1'b1;
				end
			end
			PH_EXP_SIGN, PH_EXP_NEED, PH_EXP_DIG: begin
				if (parse_at == PH_EXP_SIGN && (ch == CH_PLUS || ch == CH_MINUS)) begin
					exp_minus = (ch == CH_MINUS);
					parse_at  = PH_EXP_NEED;
				end else if (is_dig) begin
					e         = exp_count * 10 + dch;
					exp_count = (e > EXP_MAX) ? EXP_MAX : e;
					parse_at  = PH_EXP_DIG;
				end else begin
					saw_illegal = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// Scale the mantissa by the exponent, saturate, then start a fresh string
	function automatic number_t close_number();
		number_t     r;
		logic [63:0] mag;
		logic        over;
		int unsigned k;
		if (parse_at == PH_EXP_SIGN || parse_at == PH_EXP_NEED)
			saw_illegal = 1'b1;
		if (saw_illegal) begin
			r.value  = '0;
			r.status = ST_ILLEGAL;
		end else begin
			mag  = mant_mag;
			over = saw_overflow;
			if (!over) begin
				for (k = 0; k < exp_count && mag != 0 && !over; k++) begin
					if (exp_minus)
						mag = mag / TEN_U64;
					else if (mag > MAG_CAP / TEN_U64)
						over = 1'b1;
					else
						mag = mag * TEN_U64;
				end
				if (!mant_minus && mag > MAG_CAP - 1)
					over = 1'b1;
				if (mant_minus && mag > MAG_CAP)
					over = 1'b1;
			end
			if (over) begin
				r.value  = mant_minus ? -MAG_CAP : MAG_CAP - 1;
				r.status = ST_OVERFLOW;
			end else begin
				r.value  = mant_minus ? -mag : mag;
				r.status = ST_OK;
			end
		end
		clear_number();
		return r;
	endfunction

	function automatic bit idle_roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Idle percentages per stretch of the run: sender, then receiver
	function automatic int sender_pct();
		if (accepted_chars < PHASE_LEN)
			return 8;
		else if (accepted_chars < 2 * PHASE_LEN)
			return 86;
		return 0;
	endfunction

	function automatic int receiver_pct();
		if (accepted_chars < PHASE_LEN)
			return 86;
		else if (accepted_chars < 2 * PHASE_LEN)
			return 8;
		return 0;
	endfunction

	// Driver: predict each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin : drive
		text_beat_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_char  <= CH_NUL;
			drv_last  <= 1'b0;
			clear_number();
		end else begin
			if (drv_valid && text_ch.ready) begin
				absorb_char(drv_char);
				if (drv_last)
					pending_numbers.push_back(close_number());
				accepted_chars++;
			end
			if (!drv_valid || text_ch.ready) begin
				if (text_bytes.size() != 0 && !idle_roll(sender_pct())) begin
					nxt = text_bytes.pop_front();
					drv_valid <= 1'b1;
					drv_char  <= nxt.ch;
					drv_last  <= nxt.last;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		number_t want;
		if (!arst_n) begin
			rdy <= 1'b0;
		end else begin
			if (result_ch.valid && rdy) begin
				if (pending_numbers.size() == 0) begin
					$display("%0t: unexpected result value %0d status %0d", $realtime,
						result_ch.value, result_ch.status);
					mismatch_count++;
				end else begin
					want = pending_numbers.pop_front();
					if (result_ch.value !== want.value) begin
						$display("%0t: value expected %0d got %0d", $realtime,
							want.value, result_ch.value);
						mismatch_count++;
					end
					if (result_ch.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $realtime,
							want.status, result_ch.status);
						mismatch_count++;
					end
				end
			end
			rdy <= !idle_roll(receiver_pct());
		end
	end

	task automatic put_byte(byte unsigned b);
		text_buf.push_back(b);
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic put_digits(int n);
		for (int i = 0; i < n; i++)
			text_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
	endtask

	// Move the built string to the send queue, last beat marked
	task automatic end_text();
		text_beat_t b;
		for (int i = 0; i < text_buf.size(); i++) begin
			b.ch   = text_buf[i];
			b.last = (i == text_buf.size() - 1);
			text_bytes.push_back(b);
		end
		text_buf.delete();
	endtask

	task automatic put_exponent();
		put_byte($urandom_range(1) ? CH_LOW_E : CH_UP_E);
		case ($urandom_range(2))
			1: put_byte(CH_PLUS);
			2: put_byte(CH_MINUS);
			default: ;
		endcase
		put_digits($urandom_range(1, ($urandom_range(9) == 0) ? 4 : 2));
	endtask

	initial begin : stimulus
		int rand_chars;
		int pick;
		// Directed strings: small values, empty text, exponents, overflow, illegal text
		put_str("9");      end_text();
		put_str("-");      end_text();
		put_byte(CH_NUL);  end_text();
		put_str("5e");     end_text();
		put_str("1E+2");   end_text();
		put_str("7e-1");   end_text();
		put_str("x");      end_text();
		put_str("e1");     end_text();
		put_str("0e99");   end_text();
		put_str("9e99");   end_text();
		put_str("3"); put_byte(CH_NUL); put_str("z"); end_text();

		// Random strings, mostly well formed
		rand_chars = 0;
		while (rand_chars < RAND_CHARS) begin
			pick = $urandom_range(99);
			if (pick < 58) begin
				if ($urandom_range(1))
					put_byte(CH_MINUS);
				put_digits(($urandom_range(3) != 0) ? $urandom_range(1, 6) :
					$urandom_range(7, 22));
				if ($urandom_range(99) < 55)
					put_exponent();
				if ($urandom_range(9) == 0) begin
					put_byte(CH_NUL);
					repeat ($urandom_range(2)) put_byte(8'($urandom_range(255)));
				end
			end else if (pick < 70) begin
				// Hover around the signed range limits
				if ($urandom_range(1))
					put_byte(CH_MINUS);
				put_str("922337203685477580");
				put_byte(8'(CH_ZERO + $urandom_range(6, 9)));
				if ($urandom_range(2) == 0)
					put_digits($urandom_range(1, 3));
				if ($urandom_range(3) == 0)
					put_exponent();
			end else if (pick < 85) begin
				// Broken text: valid prefix, then a fault
				if ($urandom_range(1))
					put_byte(CH_MINUS);
				put_digits($urandom_range(3));
				case ($urandom_range(4))
					0: begin
						put_byte($urandom_range(1) ? CH_LOW_E : CH_UP_E);
						if ($urandom_range(1))
							put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
						if ($urandom_range(1))
							put_byte(CH_NUL);
					end
					1: put_byte(8'($urandom_range(255)));
					2: put_byte(CH_MINUS);
					3: put_byte(CH_PLUS);
					default: begin
						put_byte(CH_LOW_E);
						put_byte(CH_UP_E);
					end
				endcase
				repeat ($urandom_range(3)) put_byte(8'(CH_ZERO + $urandom_range(9)));
			end else begin
				// Noise: any byte values
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(1))
						put_byte(8'($urandom_range(255)));
					else
						case ($urandom_range(4))
							0: put_byte(CH_NUL);
							1: put_byte(CH_MINUS);
							2: put_byte(CH_PLUS);
							3: put_byte(CH_LOW_E);
							default: put_byte(8'(CH_ZERO + $urandom_range(9)));
						endcase
				end
			end
			rand_chars += text_buf.size();
			end_text();
		end

		// Hold reset, then release at a rising edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for every beat to go and every result to come back
		@(negedge clk);
		while (text_bytes.size() != 0 || drv_valid || pending_numbers.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatch_count == 0 && pending_numbers.size() == 0)
			$display("decimal_text_to_integer_unit verification clean");
		else
			$display("decimal_text_to_integer_unit verification failed");
		$finish;
	end

	// Watchdog on the whole run
	initial begin
		#20_000_000;
		$display("decimal_text_to_integer_unit verification failed");
		$finish;
	end

endmodule
